FILE: design/crc8pf_pkg.sv
// Shared types, constants and the CRC-8 byte update for the packet framer.
`default_nettype none

package crc8pf_pkg;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] PREAMBLE_HI = 8'hAA;
    localparam logic [7:0] PREAMBLE_LO = 8'h55;

    typedef struct packed {
        logic       start_packet;
        logic [7:0] packet_type;
        logic [7:0] packet_length;
        logic [7:0] payload_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       packet_end;
    } t_out;

    // One classified request, handed from front to back.
    typedef struct packed {
        logic       is_start;
        logic [7:0] ptype;
        logic [7:0] plen;
        logic [7:0] data;
        logic       has_data;
        logic       has_crc;
        logic [7:0] crc;
    } t_cmd;

    typedef enum logic [2:0] {
        SL_IDLE,
        SL_PRE_HI,
        SL_PRE_LO,
        SL_TYPE,
        SL_LEN,
        SL_DATA,
        SL_CRC
    } t_slot;

    function automatic logic [7:0] crc_feed(input logic [7:0] c, input logic [7:0] v);
        logic [7:0] x;
        x = c ^ v;
        for (int i = 0; i < 8; i++) begin
            x = {x[6:0], 1'b0} ^ (x[7] ? CRC_POLY : 8'h00);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

FILE: design/crc8pf_front.sv
// Front end: accepts input requests, tracks packet state and CRC, classifies.
`default_nettype none

module crc8pf_front
    import crc8pf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [7:0] r_crc, n_crc;
    logic [7:0] r_remaining, n_remaining;
    logic       r_open, n_open;
    logic       accept;
    logic [7:0] crc_hdr;
    logic [7:0] crc_base;
    logic [7:0] crc_data;
    logic [7:0] rem_base;
    logic [7:0] rem_next;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        crc_hdr  = crc_feed(crc_feed(8'h00, i_in.packet_type), i_in.packet_length);
        crc_base = i_in.start_packet ? crc_hdr : r_crc;
        rem_base = i_in.start_packet ? i_in.packet_length : r_remaining;
        crc_data = crc_feed(crc_base, i_in.payload_byte);
        rem_next = rem_base - 8'd1;

        n_crc       = r_crc;
        n_remaining = r_remaining;
        n_open      = r_open;
        o_push      = 1'b0;

        o_cmd.is_start = i_in.start_packet;
        o_cmd.ptype    = i_in.packet_type;
        o_cmd.plen     = i_in.packet_length;
        o_cmd.data     = i_in.payload_byte;
        o_cmd.has_data = 1'b1;
        o_cmd.has_crc  = (rem_next == 8'd0);
        o_cmd.crc      = crc_data;

        if (accept) begin
            if (i_in.start_packet && i_in.packet_length == 8'd0) begin
                // zero length: header and CRC only
                o_push         = 1'b1;
                o_cmd.has_data = 1'b0;
                o_cmd.has_crc  = 1'b1;
                o_cmd.crc      = crc_hdr;
                n_crc          = crc_hdr;
                n_remaining    = 8'd0;
                n_open         = 1'b0;
            end else if (i_in.start_packet || r_open) begin
                o_push      = 1'b1;
                n_crc       = crc_data;
                n_remaining = rem_next;
                n_open      = (rem_next != 8'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= 8'h00;
            r_remaining <= 8'h00;
            r_open      <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
            r_open      <= n_open;
        end
    end

    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_remaining == 8'd0))
        else $error("packet closed with bytes remaining");

    a_drop_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in.start_packet && !r_open) |-> !o_push)
        else $error("stray byte pushed with no packet open");

endmodule

`default_nettype wire

FILE: design/crc8pf_queue.sv
// Short request queue between front and back.
`default_nettype none

module crc8pf_queue
    import crc8pf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

endmodule

`default_nettype wire

FILE: design/crc8pf_back.sv
// Back end: expands each request into framed bytes into the output register.
`default_nettype none

module crc8pf_back
    import crc8pf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    t_slot r_slot, n_slot;
    t_slot cur;
    t_slot nxt;
    logic  load;
    logic  last;
    t_out  n_out;
    t_out  r_out;
    logic  r_out_valid;

    assign load        = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        if (r_slot == SL_IDLE) begin
            cur = i_cmd.is_start ? SL_PRE_HI : SL_DATA;
        end else begin
            cur = r_slot;
        end

        n_out.out_byte   = 8'h00;
        n_out.packet_end = 1'b0;
        last             = 1'b0;
        nxt              = SL_IDLE;

        unique case (cur)
            SL_PRE_HI: begin
                n_out.out_byte = PREAMBLE_HI;
                nxt            = SL_PRE_LO;
            end
            SL_PRE_LO: begin
                n_out.out_byte = PREAMBLE_LO;
                nxt            = SL_TYPE;
            end
            SL_TYPE: begin
                n_out.out_byte = i_cmd.ptype;
                nxt            = SL_LEN;
            end
            SL_LEN: begin
                n_out.out_byte = i_cmd.plen;
                nxt            = i_cmd.has_data ? SL_DATA : SL_CRC;
            end
            SL_DATA: begin
                n_out.out_byte = i_cmd.data;
                last           = !i_cmd.has_crc;
                nxt            = i_cmd.has_crc ? SL_CRC : SL_IDLE;
            end
            SL_CRC: begin
                n_out.out_byte   = i_cmd.crc;
                n_out.packet_end = 1'b1;
                last             = 1'b1;
            end
            default: begin
                last = 1'b1;
            end
        endcase

        n_out.run_last = last;
        o_pop          = load && last;
        n_slot         = r_slot;
        if (load) begin
            n_slot = last ? SL_IDLE : nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= SL_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot != SL_IDLE) |-> i_q_valid)
        else $error("request sequence running without queue head");

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out.run_last))
        else $error("request retired without a last byte");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_out.packet_end) |-> o_pop)
        else $error("CRC byte did not retire its request");

endmodule

`default_nettype wire

FILE: design/crc8_packet_framer_core.sv
// Top level of the CRC-8 packet framer: front end, request queue, back end.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+---------------------------
//   in      | in  | i_in_valid / o_in_stall   | i_in  (t_in)
//   out     | out | o_out_valid / i_out_stall | o_out (t_out)
//
// One output byte per cycle from the back end's byte sequencer while a request is
// queued and the output is not stalled. A mid-packet byte gives data, plus CRC if
// it closes the packet. A first byte gives preamble, type, length, data, plus CRC
// if length is 1; zero-length: preamble, type, length, CRC; strays are dropped.
// The input is stalled only when the request queue is full.
// Synchronous active-low reset clears packet state, queue and output valid.
`default_nettype none

module crc8_packet_framer_core
    import crc8pf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    crc8pf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    crc8pf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    crc8pf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
